// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions with a synchronous reset guard.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/rgbhsv_pkg.sv =====
// ---------------------------------------------------------------------------
// rgbhsv_pkg
// Shared types and constants of the RGB to HSV pixel converter.
// ---------------------------------------------------------------------------
`default_nettype none

package rgbhsv_pkg;

  localparam int unsigned CH_W  = 8;   // channel byte
  localparam int unsigned HUE_W = 15;  // hue in 1/64 degree
  localparam int unsigned SAT_W = 13;  // saturation in 1/4096
  localparam int unsigned QUO_W = 13;  // quotient bits produced by the divider
  localparam int unsigned REM_W = 20;  // partial remainder width

  localparam logic [HUE_W-1:0] HUE_FULL_TURN = 15'd23040;
  localparam logic [HUE_W-1:0] HUE_GREEN_OFS = 15'd7680;
  localparam logic [HUE_W-1:0] HUE_BLUE_OFS  = 15'd15360;

  // Largest channel, ties resolved red first then green.
  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // Payload carried through the divider steps.
  typedef struct packed {
    logic [CH_W-1:0]  value;   // max channel, also saturation divisor
    logic [CH_W-1:0]  delta;   // max - min, hue divisor
    logic [REM_W-1:0] rem_s;   // saturation partial remainder
    logic [REM_W-1:0] rem_h;   // hue partial remainder
    logic [QUO_W-1:0] q_s;     // saturation quotient
    logic [QUO_W-1:0] q_h;     // hue quotient magnitude
    sector_t          sector;
    logic             neg;     // hue channel difference is negative
    logic             gray;    // max equals min
  } div_t;

endpackage

`default_nettype wire

// ===== design/rgbhsv_div_step.sv =====
// ---------------------------------------------------------------------------
// rgbhsv_div_step
// One restoring-division step for both the saturation and the hue quotient.
// ---------------------------------------------------------------------------
`default_nettype none

module rgbhsv_div_step #(
  parameter int unsigned BIT = 0
) (
  input  wire                logic clk,
  input  wire                logic rst,
  input  wire                logic advance,
  input  wire                logic in_valid,
  input  wire rgbhsv_pkg::div_t  in_data,
  output logic               out_valid,
  output rgbhsv_pkg::div_t   out_data
);

  import rgbhsv_pkg::*;

  logic [REM_W-1:0] trial_s;
  logic [REM_W-1:0] trial_h;
  div_t             data_next;

  assign trial_s = REM_W'(in_data.value) << BIT;
  assign trial_h = REM_W'(in_data.delta) << BIT;

  always_comb begin
    data_next = in_data;
    // subtract the shifted divisor where it fits and set the quotient bit
    if (in_data.rem_s >= trial_s) begin
      data_next.rem_s  = in_data.rem_s - trial_s;
      data_next.q_s[BIT] = 1'b1;
    end
    if (in_data.rem_h >= trial_h) begin
      data_next.rem_h  = in_data.rem_h - trial_h;
      data_next.q_h[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/rgb_to_hsv_pixel_converter_core.sv =====
// ---------------------------------------------------------------------------
// rgb_to_hsv_pixel_converter_core
// Converts 8-bit RGB pixels to hue, saturation and value in fixed point.
// ---------------------------------------------------------------------------
// Each accepted transaction carries one RGB pixel and yields exactly one HSV
// transaction. Value is the largest channel; saturation is (max-min)*4096/max
// truncated (0 for black); hue is in 1/64 degree, 0..23039, and 0 for grey.
// The block is a 16-stage pipeline: one stage finds max, min and the leading
// channel, one builds the dividends, thirteen stages each retire one
// quotient bit of the two divisions (saturation and hue run side by side),
// and the last stage forms the hue offset and holds the result. Throughput
// is one pixel per clock while the output is not stalled. Every stage holds
// its transaction when the stage after it is full and stalled, so empty
// stages keep filling and a stalled output does not stop input until the
// whole pipeline is full.
// ---------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsv_pixel_converter_core (
  input  wire  logic                          clk,
  input  wire  logic                          rst,
  input  wire  logic                          in_valid,
  output logic                                in_stall,
  input  wire  logic [rgbhsv_pkg::CH_W-1:0]   red,
  input  wire  logic [rgbhsv_pkg::CH_W-1:0]   green,
  input  wire  logic [rgbhsv_pkg::CH_W-1:0]   blue,
  output logic                                out_valid,
  input  wire  logic                          out_stall,
  output logic [rgbhsv_pkg::HUE_W-1:0]        hue,
  output logic [rgbhsv_pkg::SAT_W-1:0]        saturation,
  output logic [rgbhsv_pkg::CH_W-1:0]         value
);

  import rgbhsv_pkg::*;

  // ---------------------------------------------------------------------
  // Advance chain: a stage may load when it is empty or the stage after it
  // loads in the same cycle.
  // ---------------------------------------------------------------------
  logic                 out_move;
  logic [QUO_W-1:0]     div_move;
  logic                 b_move;
  logic                 a_move;

  logic                 a_valid;
  logic                 b_valid;
  logic [QUO_W-1:0]     div_valid;

  assign out_move = !out_valid || !out_stall;
  assign b_move   = !b_valid || div_move[0];
  assign a_move   = !a_valid || b_move;
  assign in_stall = !a_move;

  // ---------------------------------------------------------------------
  // Stage A: register the pixel, find max, min and the leading channel.
  // ---------------------------------------------------------------------
  logic [CH_W-1:0] a_red;
  logic [CH_W-1:0] a_green;
  logic [CH_W-1:0] a_blue;
  logic [CH_W-1:0] a_hi;
  logic [CH_W-1:0] a_lo;
  sector_t         a_sector;

  logic [CH_W-1:0] hi_next;
  logic [CH_W-1:0] lo_next;
  sector_t         sector_next;

  always_comb begin
    // red wins ties, then green
    if (red >= green && red >= blue) begin
      sector_next = SEC_RED;
      hi_next     = red;
    end else if (green >= blue) begin
      sector_next = SEC_GREEN;
      hi_next     = green;
    end else begin
      sector_next = SEC_BLUE;
      hi_next     = blue;
    end
    lo_next = (red < green) ? red : green;
    if (blue < lo_next) begin
      lo_next = blue;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_move) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      a_red    <= red;
      a_green  <= green;
      a_blue   <= blue;
      a_hi     <= hi_next;
      a_lo     <= lo_next;
      a_sector <= sector_next;
    end
  end

  // ---------------------------------------------------------------------
  // Stage B: delta, signed channel difference and both dividends.
  // Hue dividend is |diff| * 3840, built as |diff|*4096 - |diff|*256.
  // ---------------------------------------------------------------------
  div_t           b_data;
  div_t           b_next;
  logic [CH_W:0]  diff;
  logic [CH_W-1:0] diff_abs;

  always_comb begin
    case (a_sector)
      SEC_RED:   diff = {1'b0, a_green} - {1'b0, a_blue};
      SEC_GREEN: diff = {1'b0, a_blue}  - {1'b0, a_red};
      SEC_BLUE:  diff = {1'b0, a_red}   - {1'b0, a_green};
      default:   diff = '0;
    endcase
    diff_abs = diff[CH_W] ? CH_W'(-diff) : diff[CH_W-1:0];

    b_next        = '0;
    b_next.value  = a_hi;
    b_next.delta  = a_hi - a_lo;
    b_next.rem_s  = {b_next.delta, 12'd0};
    b_next.rem_h  = {diff_abs, 12'd0} - {4'd0, diff_abs, 8'd0};
    b_next.sector = a_sector;
    b_next.neg    = diff[CH_W];
    b_next.gray   = (a_hi == a_lo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_move) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_move) begin
      b_data <= b_next;
    end
  end

  // ---------------------------------------------------------------------
  // Divider: one quotient bit per stage, most significant bit first.
  // ---------------------------------------------------------------------
  div_t div_data [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    if (k == QUO_W - 1) begin : g_last
      assign div_move[k] = !div_valid[k] || out_move;
    end else begin : g_mid
      assign div_move[k] = !div_valid[k] || div_move[k+1];
    end

    if (k == 0) begin : g_first
      rgbhsv_div_step #(
        .BIT (QUO_W - 1 - k)
      ) u_step (
        .clk       (clk),
        .rst       (rst),
        .advance   (div_move[k]),
        .in_valid  (b_valid),
        .in_data   (b_data),
        .out_valid (div_valid[k]),
        .out_data  (div_data[k])
      );
    end else begin : g_next
      rgbhsv_div_step #(
        .BIT (QUO_W - 1 - k)
      ) u_step (
        .clk       (clk),
        .rst       (rst),
        .advance   (div_move[k]),
        .in_valid  (div_valid[k-1]),
        .in_data   (div_data[k-1]),
        .out_valid (div_valid[k]),
        .out_data  (div_data[k])
      );
    end
  end

  // ---------------------------------------------------------------------
  // Output stage: place the hue at its sector offset and hold the result.
  // Red truncates toward zero and wraps negatives by a full turn; green
  // and blue floor the quotient, so drop one more when a negative quotient
  // left a remainder.
  // ---------------------------------------------------------------------
  div_t             fin;
  logic [HUE_W-1:0] q_hue;
  logic [HUE_W-1:0] round_adj;
  logic [HUE_W-1:0] hue_next;
  logic [SAT_W-1:0] sat_next;

  assign fin       = div_data[QUO_W-1];
  assign q_hue     = HUE_W'(fin.q_h);
  assign round_adj = HUE_W'(fin.rem_h != '0);

  always_comb begin
    case (fin.sector)
      SEC_RED: begin
        if (fin.neg && q_hue != '0) begin
          hue_next = HUE_FULL_TURN - q_hue;
        end else begin
          hue_next = fin.neg ? '0 : q_hue;
        end
      end
      SEC_GREEN: begin
        hue_next = fin.neg ? HUE_GREEN_OFS - q_hue - round_adj
                           : HUE_GREEN_OFS + q_hue;
      end
      SEC_BLUE: begin
        hue_next = fin.neg ? HUE_BLUE_OFS - q_hue - round_adj
                           : HUE_BLUE_OFS + q_hue;
      end
      default: begin
        hue_next = '0;
      end
    endcase
    // grey and black pixels: divisors may be zero, force both to zero
    if (fin.gray) begin
      hue_next = '0;
    end
    sat_next = fin.gray ? '0 : SAT_W'(fin.q_s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_move) begin
      out_valid <= div_valid[QUO_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_move) begin
      hue        <= hue_next;
      saturation <= sat_next;
      value      <= fin.value;
    end
  end

endmodule

`default_nettype wire

// ===== design/rgbhsv_checker.sv =====
// ---------------------------------------------------------------------------
// rgbhsv_checker
// Port-level checks of the RGB to HSV converter, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rgbhsv_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [7:0]  red,
  input wire logic [7:0]  green,
  input wire logic [7:0]  blue,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [14:0] hue,
  input wire logic [12:0] saturation,
  input wire logic [7:0]  value
);

  // hold a stalled output transaction
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  `ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable({hue, saturation, value}))

  // result ranges
  `ASSERT_IMPLIES(a_sat_range, clk, rst, out_valid, saturation <= 13'd4096)
  `ASSERT_IMPLIES(a_hue_range, clk, rst, out_valid, hue <= 15'd23039)

  // black pixel gives zero hue and saturation
  `ASSERT_IMPLIES(a_black, clk, rst, out_valid && value == '0, saturation == '0 && hue == '0)

endmodule

bind rgb_to_hsv_pixel_converter_core rgbhsv_checker u_rgbhsv_checker (.*);

`default_nettype wire

// ===== tb/sv/rgb_to_hsv_pixel_converter_core_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgb_to_hsv_pixel_converter_core_test
// Self-checking bench for the RGB to HSV pixel converter.
// ---------------------------------------------------------------------------
// Pixels are pushed through the input channel while an independent sink
// drains the output channel. At each accepted input transaction the bench
// computes the HSV it should see, in exact integer fixed point, and queues
// it; every output transaction is checked field by field against the oldest
// queued entry. Corner pixels come first, then three random runs with
// different back-pressure: a slow sink, a slow source and full rate.
// ---------------------------------------------------------------------------

module rgb_to_hsv_pixel_converter_core_test;
  import rgbhsv_pkg::*;

  localparam int HUE_PER_SIXTY    = 3840;  // 60 degrees in 1/64 degree
  localparam int SAT_SCALE        = 4096;  // saturation of 1.0
  localparam int MISMATCH_REPORTS = 10;
  localparam int RANDOM_PER_PHASE = 300;
  localparam int DRAIN_CYCLES     = 40;    // pipeline is 16 deep

  // Corner pixels as 24'hRRGGBB.
  localparam logic [23:0] CORNER_PIXELS [24] = '{
    24'h000000,  // black
    24'hFFFFFF,  // white
    24'h808080,  // mid grey
    24'h010101,  // darkest grey
    24'hFF0000, 24'h00FF00, 24'h0000FF,  // primaries
    24'hFFFF00,  // red ties green: red wins
    24'h00FFFF,  // green ties blue: green wins
    24'hFF00FF,  // red ties blue: red wins, hue wraps
    24'hFF0001,  // red lead, tiny negative hue
    24'hC8115A,  // red lead, negative non-exact quotient
    24'hFF0100,
    24'h010000, 24'h000100, 24'h000001,  // smallest nonzero
    24'hFFFEFE, 24'hFEFFFE, 24'hFEFEFF,  // delta of one
    24'h030201, 24'h010203,
    24'hFF8000, 24'h0080FF, 24'h55AAFF
  };

  localparam logic [CH_W-1:0] EDGE_BYTES [6] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF};

  typedef struct {
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] saturation;
    logic [CH_W-1:0]  value;
  } hsv_pixel_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [CH_W-1:0]     red = '0;
  logic [CH_W-1:0]     green = '0;
  logic [CH_W-1:0]     blue = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [HUE_W-1:0]    hue;
  logic [SAT_W-1:0]    saturation;
  logic [CH_W-1:0]     value;

  hsv_pixel_t hsv_due[$];   // HSV owed for accepted pixels, oldest first
  int         bad_hsv_count = 0;
  int         send_idle_pct = 0;
  int         sink_idle_pct = 0;

  rgb_to_hsv_pixel_converter_core u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hue        (hue),
    .saturation (saturation),
    .value      (value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Compute the HSV of one pixel in exact integer fixed point.
  function automatic hsv_pixel_t hsv_of_pixel(input logic [CH_W-1:0] r,
                                              input logic [CH_W-1:0] g,
                                              input logic [CH_W-1:0] b);
    hsv_pixel_t px;
    int         ri, gi, bi, hi, lo, delta, num, hue_q;
    sector_t    lead;
    ri = int'(r);
    gi = int'(g);
    bi = int'(b);
    hi = (ri > gi) ? ri : gi;
    hi = (hi > bi) ? hi : bi;
    lo = (ri < gi) ? ri : gi;
    lo = (lo < bi) ? lo : bi;
    delta = hi - lo;
    px.red = r;
    px.green = g;
    px.blue = b;
    px.value = CH_W'(hi);
    // Black has no defined saturation: hold it at zero.
    px.saturation = (hi > 0) ? SAT_W'((delta * SAT_SCALE) / hi) : '0;
    hue_q = 0;
    if (delta > 0) begin
      // Ties go to red first, then green.
      if (ri == hi) lead = SEC_RED;
      else if (gi == hi) lead = SEC_GREEN;
      else lead = SEC_BLUE;
      case (lead)
        SEC_RED:   num = HUE_PER_SIXTY * (gi - bi);
        SEC_GREEN: num = 2 * HUE_PER_SIXTY * delta + HUE_PER_SIXTY * (bi - ri);
        default:   num = 4 * HUE_PER_SIXTY * delta + HUE_PER_SIXTY * (ri - gi);
      endcase
      // Truncate toward zero first, wrap a negative angle afterwards.
      hue_q = num / delta;
      if (hue_q < 0) hue_q = hue_q + int'(HUE_FULL_TURN);
    end
    px.hue = HUE_W'(hue_q);
    return px;
  endfunction

  // Offer one pixel, hold it until accepted, then queue its HSV.
  task automatic send_pixel(input logic [CH_W-1:0] r,
                            input logic [CH_W-1:0] g,
                            input logic [CH_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    red <= r;
    green <= g;
    blue <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    hsv_due.push_back(hsv_of_pixel(r, g, b));
  endtask

  // Mostly random bytes, with a share of greys, ties and edge bytes.
  task automatic send_random_pixels(input int count);
    logic [CH_W-1:0] r, g, b;
    for (int i = 0; i < count; i++) begin
      r = CH_W'($urandom_range(255));
      g = CH_W'($urandom_range(255));
      b = CH_W'($urandom_range(255));
      case ($urandom_range(9))
        0: begin
          g = r;
          b = r;
        end
        1: g = r;
        2: b = g;
        3: b = r;
        4: begin
          r = EDGE_BYTES[$urandom_range(5)];
          g = EDGE_BYTES[$urandom_range(5)];
          b = EDGE_BYTES[$urandom_range(5)];
        end
        default: ;
      endcase
      send_pixel(r, g, b);
    end
  endtask

  task automatic test_corner_pixels();
    foreach (CORNER_PIXELS[i])
      send_pixel(CORNER_PIXELS[i][23:16], CORNER_PIXELS[i][15:8], CORNER_PIXELS[i][7:0]);
  endtask

  task automatic test_slow_sink();
    send_idle_pct = 17;
    sink_idle_pct = 46;
    send_random_pixels(RANDOM_PER_PHASE);
  endtask

  task automatic test_slow_source();
    send_idle_pct = 46;
    sink_idle_pct = 17;
    send_random_pixels(RANDOM_PER_PHASE);
  endtask

  task automatic test_full_rate();
    send_idle_pct = 0;
    sink_idle_pct = 0;
    send_random_pixels(RANDOM_PER_PHASE);
  endtask

  // Sink: check every output transaction against the oldest queued HSV,
  // then decide the stall for the next cycle.
  always @(posedge clk) begin : hsv_sink
    hsv_pixel_t want;
    if (!rst && out_valid && !out_stall) begin
      if (hsv_due.size() == 0) begin
        bad_hsv_count++;
        if (bad_hsv_count <= MISMATCH_REPORTS)
          $display("unexpected HSV transaction: hue=%0d sat=%0d value=%0d",
                   hue, saturation, value);
      end else begin
        want = hsv_due.pop_front();
        if (hue !== want.hue || saturation !== want.saturation || value !== want.value) begin
          bad_hsv_count++;
          if (bad_hsv_count <= MISMATCH_REPORTS)
            $display("HSV mismatch for rgb=(%0d,%0d,%0d): expected %0d/%0d/%0d, got %0d/%0d/%0d",
                     want.red, want.green, want.blue,
                     want.hue, want.saturation, want.value,
                     hue, saturation, value);
        end
      end
    end
    out_stall <= ($urandom_range(99) < sink_idle_pct);
  end

  initial begin
    send_idle_pct = 17;
    sink_idle_pct = 46;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_corner_pixels();
    test_slow_sink();
    test_slow_source();
    test_full_rate();

    // Drop valid, drain the pipeline, then watch for stray transactions.
    in_valid <= 1'b0;
    while (hsv_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (bad_hsv_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of about a thousand pixels.
  initial begin
    #(2_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/rgbhsv_pkg.sv
design/rgbhsv_div_step.sv
design/rgb_to_hsv_pixel_converter_core.sv
design/rgbhsv_checker.sv
tb/sv/rgb_to_hsv_pixel_converter_core_test.sv
